@@ rtl/core/bss_pkg.sv @@
// package for the byte stack with search: sizes, request and status codes,
// transaction payload types and controller states. no dependencies.
`default_nettype none

package bss_pkg;

  localparam int DEPTH   = 16;
  localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int DATA_W  = 8;
  localparam int COUNT_W = 5;

  localparam logic [1:0] REQ_PUSH   = 2'd0;
  localparam logic [1:0] REQ_POP    = 2'd1;
  localparam logic [1:0] REQ_PEEK   = 2'd2;
  localparam logic [1:0] REQ_SEARCH = 2'd3;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [DATA_W-1:0] data_value;
  } bss_in_t;

  typedef struct packed {
    logic [DATA_W-1:0]  data_out;
    logic               found;
    logic [1:0]         status;
    logic [COUNT_W-1:0] count;
  } bss_out_t;

  // result fields staged while a transaction is in progress
  typedef struct packed {
    logic [DATA_W-1:0] data_out;
    logic              found;
    logic [1:0]        status;
  } bss_res_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_SCAN,
    ST_DONE
  } bss_state_t;

endpackage

`default_nettype wire

@@ rtl/core/bss_ram.sv @@
// generic single write port, single read port ram with registered read data.
// no dependencies.
`default_nettype none

module bss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ rtl/core/byte_stack_with_search.sv @@
// top level of the byte stack with search: controller, count register and
// output register around one bss_ram. depends on bss_pkg and bss_ram.
`default_nettype none

// Byte stack (LIFO) with membership search. Each input transaction carries a
// request (push, pop, peek or search) and yields exactly one result
// transaction with the popped or peeked byte, a found flag, a status and the
// entry count after the request. The bytes sit in one RAM with a registered
// read port, so one transaction is handled at a time. A push and any request
// that fails go straight to the done state; pop and peek pass through the
// read state first, and a search passes through the scan state, reading
// entries up to and including the match, at most the count. Once the result
// has moved into the output register, the controller returns to idle and
// takes the next request, even if that result has not yet been taken
// downstream. The search rate is set by the single RAM read port, which the
// search walks from the bottom entry one per cycle.
module byte_stack_with_search
  import bss_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire bss_in_t  in_data,
  output logic          out_valid,
  input  wire logic     out_stall,
  output bss_out_t      out_data
);

  bss_state_t        state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CNT_W-1:0]  scan_idx_r, scan_idx_nxt;
  logic [DATA_W-1:0] key_r, key_nxt;
  bss_res_t          res_r, res_nxt;
  bss_out_t          out_r, out_nxt;
  logic              out_valid_r, out_valid_nxt;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [DATA_W-1:0] ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [DATA_W-1:0] ram_rdata;

  logic              in_acc;
  logic              out_free;
  logic              load_out;
  logic              is_empty;
  logic              is_full;
  logic              hit;
  logic              scan_end;
  logic [CNT_W-1:0]  cnt_inc;
  logic [CNT_W-1:0]  cnt_dec;

  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign is_empty = (cnt_r == '0);
  assign is_full  = (cnt_r == CNT_W'(DEPTH));
  assign cnt_inc  = cnt_r + CNT_W'(1);
  assign cnt_dec  = cnt_r - CNT_W'(1);
  assign hit      = (ram_rdata == key_r);
  assign scan_end = (scan_idx_r == cnt_r);

  bss_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          unique case (in_data.req_type)
            REQ_PUSH:   state_nxt = ST_DONE;
            REQ_POP:    state_nxt = is_empty ? ST_DONE : ST_READ;
            REQ_PEEK:   state_nxt = is_empty ? ST_DONE : ST_READ;
            REQ_SEARCH: state_nxt = is_empty ? ST_DONE : ST_SCAN;
            default:    state_nxt = ST_DONE;
          endcase
        end
      end
      ST_READ: state_nxt = ST_DONE;
      ST_SCAN: begin
        if (hit || scan_end) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    in_stall     = (state_r != ST_IDLE);
    ram_we       = 1'b0;
    ram_waddr    = cnt_r[ADDR_W-1:0];
    ram_wdata    = in_data.data_value;
    ram_raddr    = scan_idx_r[ADDR_W-1:0];
    cnt_nxt      = cnt_r;
    scan_idx_nxt = scan_idx_r;
    key_nxt      = key_r;
    res_nxt      = res_r;
    load_out     = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          res_nxt = '{data_out: '0, found: 1'b0, status: STAT_OK};
          unique case (in_data.req_type)
            REQ_PUSH: begin
              if (is_full) begin
                res_nxt.status = STAT_FULL;
              end else begin
                ram_we  = 1'b1;
                cnt_nxt = cnt_inc;
              end
            end
            REQ_POP: begin
              ram_raddr = cnt_dec[ADDR_W-1:0];
              if (is_empty) begin
                res_nxt.status = STAT_EMPTY;
              end else begin
                cnt_nxt = cnt_dec;
              end
            end
            REQ_PEEK: begin
              ram_raddr = cnt_dec[ADDR_W-1:0];
              if (is_empty) begin
                res_nxt.status = STAT_EMPTY;
              end
            end
            REQ_SEARCH: begin
              // start the walk at the bottom entry
              key_nxt      = in_data.data_value;
              ram_raddr    = '0;
              scan_idx_nxt = CNT_W'(1);
            end
            default: ;
          endcase
        end
      end
      ST_READ: begin
        res_nxt.data_out = ram_rdata;
      end
      ST_SCAN: begin
        // read data belongs to entry scan_idx_r - 1
        if (hit) begin
          res_nxt.found = 1'b1;
        end else if (!scan_end) begin
          ram_raddr    = scan_idx_r[ADDR_W-1:0];
          scan_idx_nxt = scan_idx_r + CNT_W'(1);
        end
      end
      ST_DONE: begin
        load_out = out_free;
      end
      default: ;
    endcase
  end

  always_comb begin
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (load_out) begin
      out_nxt.data_out = res_r.data_out;
      out_nxt.found    = res_r.found;
      out_nxt.status   = res_r.status;
      out_nxt.count    = COUNT_W'(cnt_r);
      out_valid_nxt    = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_idx_r <= scan_idx_nxt;
    key_r      <= key_nxt;
    res_r      <= res_nxt;
    out_r      <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // count never passes the capacity
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DEPTH))
    else $error("stack count above capacity");

  // an accepted push on a non-full stack bumps the count by one
  a_push_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_data.req_type == REQ_PUSH && !is_full |=> cnt_r == $past(cnt_inc))
    else $error("push did not advance count");

  // the search walk stays inside the filled part of the stack
  a_scan_idx: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SCAN |-> scan_idx_r != '0 && scan_idx_r <= cnt_r)
    else $error("search index outside stack");

  // a found flag only ever comes with ok status
  a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.found |-> out_r.status == STAT_OK)
    else $error("found reported with error status");

  // a pop or peek on a non-empty stack goes to fetch the top entry
  a_read_path: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && !is_empty && (in_data.req_type == REQ_POP || in_data.req_type == REQ_PEEK)
    |=> state_r == ST_READ)
    else $error("pop or peek skipped the read");

endmodule

`default_nettype wire
